[design/u8dec_pkg.sv]
package u8dec_pkg;

   // results one byte can cause: up to three held bytes plus the byte itself
   localparam int unsigned MAX_RES  = 4;
   localparam int unsigned HELD_NUM = 3;

   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;
   localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] CP_MIN_LEN2    = 21'h000080;
   localparam logic [20:0] CP_MIN_LEN3    = 21'h000800;
   localparam logic [20:0] CP_MIN_LEN4    = 21'h010000;

   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   // what the current byte contributes after any flushed held bytes
   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_ERR,
      TAIL_ASCII,
      TAIL_SEQ
   } tail_type;

   typedef struct packed {
      logic [20:0] cp;
      logic        ok;
      logic [2:0]  used;
   } res_type;

endpackage

[design/utf8_stream_decoder_validator.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_data_byte, req_end_of_string
// rsp     | out       | rsp_valid/rsp_stall  | rsp_code_point, rsp_valid_res, rsp_bytes_used,
//         |           |                      | rsp_last_of_run, rsp_string_done,
//         |           |                      | rsp_string_all_valid
// csr     | in        | csr_wr_en            | csr_wr_data (replace_invalid)
//
// one word is decoded in the cycle it is accepted; all its results land in a four-entry
// result buffer and leave one per cycle unless rsp_stall holds them, the first on the
// next cycle; a word giving zero or one result sustains one word per cycle while
// rsp_stall is low; more results hold the input until the single-read buffer drains
// reset (synchronous) empties the buffer, drops any open sequence and sets
// replace_invalid to 1
// req_stall rises while the buffer holds results that will not drain this cycle
module utf8_stream_decoder_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_valid_res,
   output logic [2:0]  rsp_bytes_used,
   output logic        rsp_last_of_run,
   output logic        rsp_string_done,
   output logic        rsp_string_all_valid,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // configuration
   logic replace_ff;

   // decoder state
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic [20:0] partial_ff, partial_in;
   logic [7:0]  held_ff [u8dec_pkg::HELD_NUM];
   logic        held_we;
   logic [1:0]  held_wa;
   logic        str_ok_ff, str_ok_in;

   // result buffer
   u8dec_pkg::res_type res_ff [u8dec_pkg::MAX_RES];
   u8dec_pkg::res_type res_in [u8dec_pkg::MAX_RES];
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  rd_ff, rd_in;
   logic        done_ff, done_in;
   logic        all_ok_ff, all_ok_in;

   logic req_fire, rsp_fire;

   // decode signals
   logic [7:0]  b;
   logic        cont;
   logic [20:0] cp_cat;
   logic [2:0]  cnt_next;
   logic        seq_end;
   logic        bad;
   logic        is_ascii, is_lead;
   logic [2:0]  lead_len;
   logic [20:0] lead_cp;
   logic [1:0]  flush_num;
   u8dec_pkg::tail_type tail;
   logic [7:0]  slot_byte [u8dec_pkg::MAX_RES];
   logic [2:0]  res_num;
   logic        has_err;
   logic [20:0] err_cp;

   assign b       = req_data_byte;
   assign cont    = (b[7:6] == 2'b10);
   // shift in six payload bits, dropping what falls off the 21-bit value
   assign cp_cat  = {partial_ff[14:0], b[5:0]};
   assign cnt_next = {1'b0, held_cnt_ff} + 3'd1;
   assign seq_end = (cnt_next >= seq_len_ff);

   // shortest form, range and surrogate checks on a finished sequence
   always_comb begin
      bad = ((seq_len_ff == u8dec_pkg::SEQ_LEN2) && (cp_cat < u8dec_pkg::CP_MIN_LEN2)) ||
            ((seq_len_ff == u8dec_pkg::SEQ_LEN3) && (cp_cat < u8dec_pkg::CP_MIN_LEN3)) ||
            ((seq_len_ff == u8dec_pkg::SEQ_LEN4) &&
             ((cp_cat < u8dec_pkg::CP_MIN_LEN4) || (cp_cat > u8dec_pkg::CP_MAX))) ||
            ((cp_cat >= u8dec_pkg::CP_SURR_LO) && (cp_cat <= u8dec_pkg::CP_SURR_HI));
   end

   // lead byte classification
   always_comb begin
      is_ascii = ~b[7];
      is_lead  = 1'b1;
      lead_len = u8dec_pkg::SEQ_LEN2;
      lead_cp  = {16'd0, b[4:0]};
      if (b[7:5] == 3'b110) begin
         lead_len = u8dec_pkg::SEQ_LEN2;
         lead_cp  = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         lead_len = u8dec_pkg::SEQ_LEN3;
         lead_cp  = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         lead_len = u8dec_pkg::SEQ_LEN4;
         lead_cp  = {18'd0, b[2:0]};
      end else begin
         is_lead = 1'b0;
      end
   end

   assign err_cp = replace_ff ? u8dec_pkg::CP_REPLACEMENT : {13'd0, b};

   // case split: how many held bytes flush, what the byte itself yields,
   // and the decoder state left behind
   always_comb begin
      flush_num   = 2'd0;
      tail        = u8dec_pkg::TAIL_NONE;
      held_cnt_in = 2'd0;
      seq_len_in  = 3'd0;
      partial_in  = 21'd0;
      held_we     = 1'b0;
      held_wa     = held_cnt_ff;
      if ((held_cnt_ff != 2'd0) && cont) begin
         if (seq_end) begin
            if (bad) begin
               flush_num = held_cnt_ff;
               tail      = u8dec_pkg::TAIL_ERR;
            end else begin
               tail = u8dec_pkg::TAIL_SEQ;
            end
         end else if (held_cnt_ff != 2'd3) begin
            if (req_end_of_string) begin
               // truncated at end of string
               flush_num = held_cnt_ff;
               tail      = u8dec_pkg::TAIL_ERR;
            end else begin
               held_we     = 1'b1;
               held_cnt_in = cnt_next[1:0];
               seq_len_in  = seq_len_ff;
               partial_in  = cp_cat;
            end
         end else begin
            flush_num = held_cnt_ff;
            tail      = u8dec_pkg::TAIL_ERR;
         end
      end else begin
         // no open sequence, or broken by a non-continuation: byte is a new lead
         flush_num = held_cnt_ff;
         held_wa   = 2'd0;
         if (is_ascii) begin
            tail = u8dec_pkg::TAIL_ASCII;
         end else if (!is_lead || req_end_of_string) begin
            tail = u8dec_pkg::TAIL_ERR;
         end else begin
            held_we     = 1'b1;
            held_cnt_in = 2'd1;
            seq_len_in  = lead_len;
            partial_in  = lead_cp;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < int'(u8dec_pkg::HELD_NUM); i++) begin
         slot_byte[i] = held_ff[i];
      end
      slot_byte[u8dec_pkg::MAX_RES-1] = b;
   end

   // fill result slots: flushed held bytes first, then the byte's own result
   always_comb begin
      for (int i = 0; i < int'(u8dec_pkg::MAX_RES); i++) begin
         res_in[i].cp   = replace_ff ? u8dec_pkg::CP_REPLACEMENT : {13'd0, slot_byte[i]};
         res_in[i].ok   = 1'b0;
         res_in[i].used = 3'd1;
         if (3'(i) == {1'b0, flush_num}) begin
            case (tail)
               u8dec_pkg::TAIL_ASCII: begin
                  res_in[i].cp = {13'd0, b};
                  res_in[i].ok = 1'b1;
               end
               u8dec_pkg::TAIL_SEQ: begin
                  res_in[i].cp   = cp_cat;
                  res_in[i].ok   = 1'b1;
                  res_in[i].used = seq_len_ff;
               end
               default: begin
                  res_in[i].cp = err_cp;
               end
            endcase
         end
      end
   end

   assign res_num = {1'b0, flush_num} + ((tail != u8dec_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
   assign has_err = (flush_num != 2'd0) || (tail == u8dec_pkg::TAIL_ERR);
   assign str_ok_in = req_end_of_string ? 1'b1 : (str_ok_ff & ~has_err);

   // handshakes: take a word once the buffer drains by the end of this cycle
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_fire  = rsp_valid & ~rsp_stall;
   assign req_stall = (cnt_ff > 3'd1) || ((cnt_ff == 3'd1) && rsp_stall);
   assign req_fire  = req_valid & ~req_stall;

   always_comb begin
      cnt_in    = cnt_ff;
      rd_in     = rd_ff;
      done_in   = done_ff;
      all_ok_in = all_ok_ff;
      if (req_fire) begin
         cnt_in    = res_num;
         rd_in     = 2'd0;
         done_in   = req_end_of_string;
         all_ok_in = str_ok_ff & ~has_err;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 3'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replace_ff  <= 1'b1;
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
         partial_ff  <= 21'd0;
         str_ok_ff   <= 1'b1;
         cnt_ff      <= 3'd0;
         rd_ff       <= 2'd0;
         done_ff     <= 1'b0;
         all_ok_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            replace_ff <= csr_wr_data;
         end
         if (req_fire) begin
            held_cnt_ff <= held_cnt_in;
            seq_len_ff  <= seq_len_in;
            partial_ff  <= partial_in;
            str_ok_ff   <= str_ok_in;
         end
         cnt_ff    <= cnt_in;
         rd_ff     <= rd_in;
         done_ff   <= done_in;
         all_ok_ff <= all_ok_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (req_fire && held_we) begin
         held_ff[held_wa] <= b;
      end
      if (req_fire) begin
         for (int i = 0; i < int'(u8dec_pkg::MAX_RES); i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   // output word from the read slot; run and string marks ride the last one
   assign rsp_code_point       = res_ff[rd_ff].cp;
   assign rsp_valid_res        = res_ff[rd_ff].ok;
   assign rsp_bytes_used       = res_ff[rd_ff].used;
   assign rsp_last_of_run      = (cnt_ff == 3'd1);
   assign rsp_string_done      = (cnt_ff == 3'd1) & done_ff;
   assign rsp_string_all_valid = (cnt_ff == 3'd1) & done_ff & all_ok_ff;

   // buffer never overfills
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(u8dec_pkg::MAX_RES))
      else $error("result buffer count out of range");

   // an open sequence always has fewer held bytes than its length
   a_open_seq: assert property (@(posedge clock) disable iff (reset)
      (held_cnt_ff != 2'd0) |-> ((seq_len_ff >= u8dec_pkg::SEQ_LEN2) &&
                                 (seq_len_ff <= u8dec_pkg::SEQ_LEN4) &&
                                 ({1'b0, held_cnt_ff} < seq_len_ff)))
      else $error("held count inconsistent with sequence length");

   // a word is taken only when pending results are gone by this edge
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ((cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_fire)))
      else $error("word accepted over undelivered results");

   // an end-marked word always produces at least one result
   a_eos_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_end_of_string) |=> (rsp_valid && done_ff))
      else $error("end of string produced no result");

endmodule

[dv/utf8_decode_checker.sv]
`timescale 1ns / 1ps

module utf8_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [20:0] rsp_code_point,
   input  logic        rsp_valid_res,
   input  logic [2:0]  rsp_bytes_used,
   input  logic        rsp_last_of_run,
   input  logic        rsp_string_done,
   input  logic        rsp_string_all_valid,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int unsigned outstanding,
   output int unsigned fail_count
);

   typedef struct packed {
      logic [20:0] code_point;
      logic        well_formed;
      logic [2:0]  bytes_used;
      logic        run_last;
      logic        str_done;
      logic        str_valid;
   } cp_result_type;

   cp_result_type expected_cps[$];
   cp_result_type run_buf[u8dec_pkg::MAX_RES];
   cp_result_type want;
   int unsigned   run_n;
   int unsigned   err_cnt = 0;

   // decoder state mirror
   logic        dec_replace;
   logic [1:0]  dec_held_cnt;
   logic [2:0]  dec_seq_len;
   logic [20:0] dec_partial;
   logic [7:0]  dec_held[u8dec_pkg::HELD_NUM];
   logic        dec_str_ok;

   task automatic push_result(input logic [20:0] cp, input logic ok, input logic [2:0] used);
      if (run_n < u8dec_pkg::MAX_RES) begin
         run_buf[run_n] = '{cp, ok, used, 1'b0, 1'b0, 1'b0};
         run_n++;
         if (!ok) dec_str_ok = 1'b0;
      end
   endtask

   task automatic push_error(input logic [7:0] b);
      push_result(dec_replace ? u8dec_pkg::CP_REPLACEMENT : {13'd0, b}, 1'b0, 3'd1);
   endtask

   task automatic flush_held();
      for (int i = 0; i < dec_held_cnt; i++) push_error(dec_held[i]);
      dec_held_cnt = '0;
      dec_seq_len  = '0;
      dec_partial  = '0;
   endtask

   task automatic take_lead(input logic [7:0] b);
      if (!b[7]) begin
         push_result({13'd0, b}, 1'b1, 3'd1);
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
         dec_held[0]  = b;
         dec_held_cnt = 2'd1;
         if (!b[5]) begin
            dec_seq_len = u8dec_pkg::SEQ_LEN2;
            dec_partial = {16'd0, b[4:0]};
         end else if (!b[4]) begin
            dec_seq_len = u8dec_pkg::SEQ_LEN3;
            dec_partial = {17'd0, b[3:0]};
         end else begin
            dec_seq_len = u8dec_pkg::SEQ_LEN4;
            dec_partial = {18'd0, b[2:0]};
         end
      end else begin
         push_error(b);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eos);
      logic [20:0] cp;
      logic [2:0]  cnt;
      logic        bad;
      run_n = 0;
      if (dec_held_cnt != 0) begin
         if (b[7:6] == 2'b10) begin
            cp  = {dec_partial[14:0], b[5:0]};
            cnt = {1'b0, dec_held_cnt} + 3'd1;
            if (cnt >= dec_seq_len) begin
               bad = (dec_seq_len == u8dec_pkg::SEQ_LEN2 && cp < u8dec_pkg::CP_MIN_LEN2) ||
                     (dec_seq_len == u8dec_pkg::SEQ_LEN3 && cp < u8dec_pkg::CP_MIN_LEN3) ||
                     (dec_seq_len == u8dec_pkg::SEQ_LEN4 &&
                      (cp < u8dec_pkg::CP_MIN_LEN4 || cp > u8dec_pkg::CP_MAX)) ||
                     (cp >= u8dec_pkg::CP_SURR_LO && cp <= u8dec_pkg::CP_SURR_HI);
               if (bad) begin
                  flush_held();
                  push_error(b);
               end else begin
                  push_result(cp, 1'b1, dec_seq_len);
                  dec_held_cnt = '0;
                  dec_seq_len  = '0;
                  dec_partial  = '0;
               end
            end else begin
               dec_held[dec_held_cnt] = b;
               dec_held_cnt = cnt[1:0];
               dec_partial  = cp;
            end
         end else begin
            flush_held();
            take_lead(b);
         end
      end else begin
         take_lead(b);
      end
      if (eos) begin
         if (dec_held_cnt != 0) flush_held();
         if (run_n > 0) begin
            run_buf[run_n-1].str_done  = 1'b1;
            run_buf[run_n-1].str_valid = dec_str_ok;
         end
         dec_str_ok = 1'b1;
      end
      if (run_n > 0) run_buf[run_n-1].run_last = 1'b1;
      for (int i = 0; i < run_n; i++) expected_cps = {expected_cps, run_buf[i]};
   endtask

   task automatic check_field(input string what, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         err_cnt++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_cps.delete();
         dec_replace  = 1'b1;
         dec_held_cnt = '0;
         dec_seq_len  = '0;
         dec_partial  = '0;
         dec_str_ok   = 1'b1;
      end else begin
         if (csr_wr_en) dec_replace = csr_wr_data;
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_end_of_string);
         if (rsp_valid && !rsp_stall) begin
            if (expected_cps.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected word, expected none actual code_point %0h",
                        $time, rsp_code_point);
            end else begin
               want = expected_cps.pop_front();
               check_field("code_point", want.code_point, rsp_code_point);
               check_field("valid_res", want.well_formed, rsp_valid_res);
               check_field("bytes_used", want.bytes_used, rsp_bytes_used);
               check_field("last_of_run", want.run_last, rsp_last_of_run);
               check_field("string_done", want.str_done, rsp_string_done);
               check_field("string_all_valid", want.str_valid, rsp_string_all_valid);
            end
         end
      end
      outstanding <= expected_cps.size();
      fail_count  <= err_cnt;
   end

endmodule

[dv/tb_utf8_stream_decoder_validator.sv]
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_validator;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned PHASE_WORDS  = 150;
   // results leave after the word is registered; this margin covers that
   localparam int unsigned DRAIN_CYCLES = 8;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic [7:0]  req_data_byte     = '0;
   logic        req_end_of_string = 1'b0;
   logic        rsp_stall         = 1'b0;
   logic        csr_wr_en         = 1'b0;
   logic        csr_wr_data       = 1'b0;

   logic        req_stall;
   logic        rsp_valid;
   logic [20:0] rsp_code_point;
   logic        rsp_valid_res;
   logic [2:0]  rsp_bytes_used;
   logic        rsp_last_of_run;
   logic        rsp_string_done;
   logic        rsp_string_all_valid;

   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned cycle_cnt   = 0;
   int unsigned stall_left  = 0;
   int unsigned words_sent  = 0;
   logic        req_idle_on = 1'b0;
   logic        rsp_idle_on = 1'b0;

   // bytes of the string being built, {end mark, byte} for the directed list
   logic [7:0]  str_bytes[$];
   logic [8:0]  directed_words[$];

   utf8_stream_decoder_validator u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_end_of_string    (req_end_of_string),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_code_point       (rsp_code_point),
      .rsp_valid_res        (rsp_valid_res),
      .rsp_bytes_used       (rsp_bytes_used),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_string_done      (rsp_string_done),
      .rsp_string_all_valid (rsp_string_all_valid),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   utf8_decode_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_end_of_string    (req_end_of_string),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_code_point       (rsp_code_point),
      .rsp_valid_res        (rsp_valid_res),
      .rsp_bytes_used       (rsp_bytes_used),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_string_done      (rsp_string_done),
      .rsp_string_all_valid (rsp_string_all_valid),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .outstanding          (outstanding),
      .fail_count           (fail_count)
   );

   always #5 clock = ~clock;

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side back-pressure: random bursts of stall
   always @(posedge clock) begin
      if (reset || !rsp_idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // present one word and hold it until the block takes it
   task automatic send_word(input logic [7:0] b, input logic eos);
      // optional gap before the word
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // send the built string, end mark on its last byte
   task automatic send_string();
      for (int i = 0; i < str_bytes.size(); i++)
         send_word(str_bytes[i], i == str_bytes.size() - 1);
      str_bytes.delete();
   endtask

   // wait until every predicted word has come out, then let the block settle
   task automatic wait_idle();
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic append_byte(input logic [7:0] v);
      str_bytes = {str_bytes, v};
   endtask

   function automatic logic [7:0] rand_cont();
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   // a scalar value that fits the given encoded length in shortest form
   function automatic logic [20:0] rand_code_point(input int unsigned len);
      logic [20:0] cp;
      case (len)
         1: cp = 21'($urandom_range(0, 16'h007F));
         2: cp = 21'($urandom_range(16'h0080, 16'h07FF));
         3: begin
            cp = 21'($urandom_range(16'h0800, 16'hFFFF));
            // steer clear of the surrogate block
            if (cp >= u8dec_pkg::CP_SURR_LO && cp <= u8dec_pkg::CP_SURR_HI) cp ^= 21'h001000;
         end
         default: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
      endcase
      return cp;
   endfunction

   task automatic push_code_point(input logic [20:0] cp, input int unsigned len);
      case (len)
         1: append_byte(cp[7:0]);
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // one unit of text: mostly well formed, the rest noise and broken sequences
   task automatic add_unit();
      int unsigned kind;
      int unsigned len;
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
         len = $urandom_range(1, 4);
         push_code_point(rand_code_point(len), len);
      end else begin
         case (kind)
            13: append_byte(8'($urandom_range(0, 255)));
            // lead that can never start a sequence
            14: append_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                 : 8'($urandom_range(8'hF8, 8'hFF)));
            // sequence cut short, next unit or end of string breaks it
            15: begin
               len = $urandom_range(2, 4);
               push_code_point(rand_code_point(len), len);
               repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
            end
            // overlong forms
            16: begin
               case ($urandom_range(0, 2))
                  0: append_byte(8'($urandom_range(8'hC0, 8'hC1)));
                  1: begin
                     append_byte(8'hE0);
                     append_byte(8'($urandom_range(8'h80, 8'h9F)));
                  end
                  default: begin
                     append_byte(8'hF0);
                     append_byte(8'($urandom_range(8'h80, 8'h8F)));
                     append_byte(rand_cont());
                  end
               endcase
               append_byte(rand_cont());
            end
            // encoded surrogate
            17: begin
               append_byte(8'hED);
               append_byte(8'($urandom_range(8'hA0, 8'hBF)));
               append_byte(rand_cont());
            end
            // above the code space
            18: begin
               if ($urandom_range(0, 1)) begin
                  append_byte(8'hF4);
                  append_byte(8'($urandom_range(8'h90, 8'hBF)));
               end else begin
                  append_byte(8'($urandom_range(8'hF5, 8'hF7)));
                  append_byte(rand_cont());
               end
               append_byte(rand_cont());
               append_byte(rand_cont());
            end
            // stray continuation byte
            default: append_byte(rand_cont());
         endcase
      end
   endtask

   // set the error mode while idle, then stream random strings
   task automatic run_phase(input logic mode, input logic with_idle);
      int unsigned start_cnt;
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      start_cnt = words_sent;
      while (words_sent - start_cnt < PHASE_WORDS) begin
         repeat ($urandom_range(1, 6)) add_unit();
         // some strings run with no idling at all
         if (with_idle) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on <= ($urandom_range(0, 3) != 0);
         end else begin
            req_idle_on = 1'b0;
            rsp_idle_on <= 1'b0;
         end
         send_string();
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      // {end mark, byte}
      directed_words = '{
         9'h100,                          // nul, alone
         9'h080, 9'h0F8, 9'h1FF,          // bad leads
         9'h0C2, 9'h180,                  // smallest two-byte value
         9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,  // top of the code space
         9'h0C0, 9'h1AF,                  // overlong two-byte
         9'h0ED, 9'h0A0, 9'h180,          // surrogate
         9'h0F4, 9'h090, 9'h080, 9'h180,  // just above the code space
         9'h0F0, 9'h090, 9'h080, 9'h141,  // three held bytes broken by ascii
         9'h0E2, 9'h182,                  // truncated at end of string
         9'h17F                           // largest ascii
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words run with the reset error mode
      foreach (directed_words[i]) send_word(directed_words[i][7:0], directed_words[i][8]);
      req_valid <= 1'b0;

      run_phase(1'b0, 1'b1);
      run_phase(1'b1, 1'b1);
      // last part runs flat out on both sides
      run_phase(1'b0, 1'b0);

      wait_idle();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
